>>> hdl/efsa_pkg.sv
// Package for the earliest-free-server assignment block.
// Holds field widths, reset constants and the address-width helper.
// Used by efsa_ram and earliest_free_server_assign; depends on nothing.
package efsa_pkg;

	localparam int MAX_SERVERS_DEF = 16;

	localparam int DUR_W   = 16;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 16;
	localparam int NUM_W   = 5;

	localparam logic [NUM_W-1:0] SERVER_COUNT_RST = 5'd16;

	// address bits for a store of the given depth, at least one
	function automatic int addr_width(input int depth);
		int w;
		w = (depth > 1) ? $clog2(depth) : 1;
		return w;
	endfunction

endpackage

>>> hdl/efsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the server table; depends on efsa_pkg for the address width.
module efsa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = efsa_pkg::MAX_SERVERS_DEF
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [efsa_pkg::addr_width(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [efsa_pkg::addr_width(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/earliest_free_server_assign.sv
// Earliest-free-server assignment: one comparator scans the server table once per job.
// Each job is scanned in ST_SCAN (table read, then compare), then written back in ST_UPD, which loads the result.
// The scan reads one table entry a cycle; in_stall stays high until the update, so no new job is taken meanwhile.
// A full result register holds the update back until the result is taken.
// Reset (arst_n low) clears all finish times and counts at once via per-entry valid bits,
// and sets server_count to 16. Depends on efsa_pkg and efsa_ram.
module earliest_free_server_assign #(
	parameter int MAX_SERVERS = efsa_pkg::MAX_SERVERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [efsa_pkg::NUM_W-1:0]         server_count,
	// job channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [efsa_pkg::DUR_W-1:0]         job_duration,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [efsa_pkg::NUM_W-1:0]         server_number,
	output logic [efsa_pkg::COUNT_W-1:0]       server_job_count,
	output logic [efsa_pkg::TIME_W-1:0]        server_finish_time
);

	localparam int IDX_W   = efsa_pkg::addr_width(MAX_SERVERS);
	localparam int TIME_W  = efsa_pkg::TIME_W;
	localparam int COUNT_W = efsa_pkg::COUNT_W;
	localparam int ENTRY_W = TIME_W + COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                         state_q;
	logic [efsa_pkg::NUM_W-1:0]     cfg_count_q;
	logic [efsa_pkg::DUR_W-1:0]     dur_q;
	logic [IDX_W-1:0]               last_idx_q;
	logic [IDX_W-1:0]               rd_idx_q;
	logic                           issuing_q;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               idx_s1;
	logic [IDX_W-1:0]               best_idx_q;
	logic [TIME_W-1:0]              best_time_q;
	logic [COUNT_W-1:0]             best_cnt_q;
	logic [MAX_SERVERS-1:0]         valid_q;

	logic                           out_valid_q;
	logic [efsa_pkg::NUM_W-1:0]     server_number_q;
	logic [COUNT_W-1:0]             job_count_q;
	logic [TIME_W-1:0]              finish_time_q;

	logic [31:0]                    act_n;
	logic                           accept;
	logic                           rd_en;
	logic [ENTRY_W-1:0]             rd_data;
	logic [TIME_W-1:0]              cur_time;
	logic [COUNT_W-1:0]             cur_cnt;
	logic                           do_upd;
	logic [TIME_W:0]                sum;
	logic [TIME_W-1:0]              new_time;
	logic [COUNT_W-1:0]             new_cnt;
	logic [31:0]                    number_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;

	// clamp the register to 1..MAX_SERVERS
	always_comb begin
		act_n = {27'd0, cfg_count_q};
		if (act_n == 32'd0) begin
			act_n = 32'd1;
		end
		if (act_n > 32'(MAX_SERVERS)) begin
			act_n = 32'(MAX_SERVERS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= efsa_pkg::SERVER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			cfg_count_q <= server_count;
		end
	end

	assign rd_en = (state_q == ST_SCAN) && issuing_q;

	efsa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SERVERS)
	) u_table (
		.clk     (clk),
		.wr_en   (do_upd),
		.wr_addr (best_idx_q),
		.wr_data ({new_cnt, new_time}),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// an entry never written since reset reads as zero
	assign cur_time = valid_q[idx_s1] ? rd_data[TIME_W-1:0] : '0;
	assign cur_cnt  = valid_q[idx_s1] ? rd_data[ENTRY_W-1:TIME_W] : '0;

	assign do_upd      = (state_q == ST_UPD) && !(out_valid_q && out_stall);
	assign sum         = {1'b0, best_time_q} + {{(TIME_W + 1 - efsa_pkg::DUR_W){1'b0}}, dur_q};
	assign new_time    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	assign new_cnt     = (best_cnt_q == '1) ? best_cnt_q : best_cnt_q + COUNT_W'(1);
	assign number_full = {{(32 - IDX_W){1'b0}}, best_idx_q} + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issuing_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						issuing_q <= 1'b1;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issuing_q;
					if (issuing_q && rd_idx_q == last_idx_q) begin
						issuing_q <= 1'b0;
					end
					if (rd_vld_s1 && idx_s1 == last_idx_q) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					rd_vld_s1 <= 1'b0;
					if (do_upd) begin
						valid_q[best_idx_q] <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					issuing_q <= 1'b0;
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// scan datapath: one table read and one compare a cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q      <= job_duration;
			last_idx_q <= IDX_W'(act_n - 32'd1);
			rd_idx_q   <= '0;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q;
			if (rd_idx_q != last_idx_q) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
		// strict compare keeps the lowest server on a tie
		if ((state_q == ST_SCAN) && rd_vld_s1 &&
		    (idx_s1 == '0 || cur_time < best_time_q)) begin
			best_idx_q  <= idx_s1;
			best_time_q <= cur_time;
			best_cnt_q  <= cur_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_upd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd) begin
			server_number_q <= number_full[efsa_pkg::NUM_W-1:0];
			job_count_q     <= new_cnt;
			finish_time_q   <= new_time;
		end
	end

	assign out_valid          = out_valid_q;
	assign server_number      = server_number_q;
	assign server_job_count   = job_count_q;
	assign server_finish_time = finish_time_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("block ready right after taking an item");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(issuing_q || rd_vld_s1) |-> (state_q == ST_SCAN))
		else $error("table read outside the scan");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (best_idx_q <= last_idx_q))
		else $error("chosen server outside the active range");

	a_update_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		do_upd |=> (out_valid && state_q == ST_IDLE))
		else $error("update did not present a result");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

endmodule
